### rtl/command_retry_queue_core_assert.svh
// Assertion macros shared by the command retry queue checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef COMMAND_RETRY_QUEUE_CORE_ASSERT_SVH
`define COMMAND_RETRY_QUEUE_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define CRQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("crq assertion failed");

// Clocked assertion, also checked during reset.
`define CRQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("crq assertion failed");

`endif

### rtl/crq_pkg.sv
// Shared types and constants of the command retry queue.
// No dependencies; imported by the core, the checker and the testbench.
package crq_pkg;

  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned MaxPayload    = 512;

  localparam logic [15:0] RetryIntervalRst = 16'd1000;
  localparam logic [3:0]  MaxAttemptsRst   = 4'd3;
  localparam logic [31:0] StartSequenceRst = 32'd1;

  typedef enum logic [1:0] {
    CFG_RETRY_INTERVAL = 2'd0,
    CFG_MAX_ATTEMPTS   = 2'd1,
    CFG_START_SEQUENCE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    EV_IDLE       = 4'd0,
    EV_ENQUEUED   = 4'd1,
    EV_FULL       = 4'd2,
    EV_BAD_LENGTH = 4'd3,
    EV_TRANSMIT   = 4'd4,
    EV_DELIVERED  = 4'd5,
    EV_NACK       = 4'd6,
    EV_UNEXP_ACK  = 4'd7,
    EV_FAILED     = 4'd8
  } event_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [31:0] sequence_nr;
    logic [7:0]  handle;
    logic [9:0]  length;
    logic [31:0] last_sent;
    logic [3:0]  attempts;
  } entry_t;

endpackage

### rtl/command_retry_queue_core.sv
// Command retry queue core: stop-and-wait retransmit FIFO of outgoing commands.
// Depends on crq_pkg and crq_ram.
//
// Each accepted transaction (enqueue, acknowledgement or time tick) yields
// exactly one result transaction. The queue entries live in one RAM with a
// registered read; the head entry is read while the core waits for input, and
// in the following cycle the core decides and, once the result register can
// take it, writes the modified entry back (tail on enqueue, head on transmit)
// and loads the result register. An item therefore passes the RAM read and
// then the decide/write-back, the latter waiting while the result register
// is stalled. Input stall is high while an item is being executed; a result
// waiting in the output register does not hold off the next input. Sequence
// numbers count up modulo 2^32 and skip zero; writing start_sequence reloads
// the counter. Entries that were never written are never read, so the RAM
// needs no clearing pass after reset. Configuration writes are taken on any
// cycle with cfg_we_i high and are expected only while the core is idle.
module command_retry_queue_core #(
  parameter int unsigned QUEUE_DEPTH = crq_pkg::QueueDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       command_i,
  input  logic [7:0]                       message_handle_i,
  input  logic [9:0]                       payload_length_i,
  input  logic [31:0]                      ack_sequence_i,
  input  logic                             ack_ok_i,
  input  logic [31:0]                      now_ms_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [3:0]                       event_res_o,
  output logic [31:0]                      sequence_res_o,
  output logic [7:0]                       out_handle_o,
  output logic [9:0]                       out_length_o,
  output logic [3:0]                       attempt_count_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_depth_o
);

  import crq_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IdxLast = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   DepthW  = (CNT_W + 1)'(QUEUE_DEPTH);
  localparam logic [9:0]       MaxLen  = 10'(MaxPayload);

  // configuration registers
  logic [15:0] retry_interval_q;
  logic [3:0]  max_attempts_q;
  logic [31:0] next_seq_q, next_seq_d;

  // queue pointers
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;

  // captured transaction
  cmd_e        cmd_q;
  logic [7:0]  handle_q;
  logic [9:0]  length_q;
  logic [31:0] ack_seq_q;
  logic        ack_ok_q;
  logic [31:0] now_q;

  state_e state_q, state_d;
  logic   accept;
  logic   fire;

  // RAM access
  entry_t           rd_entry;
  entry_t           wr_entry;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [CNT_W:0]   tail_sum;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W-1:0] head_inc;

  // result
  event_e      ev;
  logic [31:0] res_seq;
  logic [7:0]  res_handle;
  logic [9:0]  res_length;
  logic [3:0]  res_att;

  logic              out_valid_q;
  logic [3:0]        event_q;
  logic [31:0]       seq_res_q;
  logic [7:0]        handle_res_q;
  logic [9:0]        length_res_q;
  logic [3:0]        att_res_q;
  logic [CNT_W-1:0]  depth_res_q;

  logic [31:0] elapsed;
  logic [31:0] seq_plus;

  crq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_crq_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_entry),
    .raddr_i(head_q),
    .rdata_o(rd_entry)
  );

  // --- control FSM ---
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    fire       = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      // result register must be free or draining this cycle
      ST_EXEC: fire = !out_valid_q || !out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  // --- pointer arithmetic ---
  assign tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
  assign tail_idx = (tail_sum >= DepthW) ? IDX_W'(tail_sum - DepthW) : IDX_W'(tail_sum);
  assign head_inc = (head_q == IdxLast) ? '0 : head_q + 1'b1;
  assign elapsed  = now_q - rd_entry.last_sent;
  assign seq_plus = next_seq_q + 32'd1;

  // --- decide and write back ---
  always_comb begin
    ev         = EV_IDLE;
    res_seq    = '0;
    res_handle = '0;
    res_length = '0;
    res_att    = '0;
    ram_we     = 1'b0;
    ram_waddr  = head_q;
    wr_entry   = rd_entry;
    head_d     = head_q;
    count_d    = count_q;
    next_seq_d = next_seq_q;
    case (cmd_q)
      CMD_ENQUEUE: begin
        res_handle = handle_q;
        res_length = length_q;
        if (length_q > MaxLen) begin
          ev = EV_BAD_LENGTH;
        end else if (count_q >= CntFull) begin
          ev = EV_FULL;
        end else begin
          ev                   = EV_ENQUEUED;
          res_seq              = next_seq_q;
          ram_we               = 1'b1;
          ram_waddr            = tail_idx;
          wr_entry.sequence_nr = next_seq_q;
          wr_entry.handle      = handle_q;
          wr_entry.length      = length_q;
          wr_entry.last_sent   = '0;
          wr_entry.attempts    = '0;
          next_seq_d           = (seq_plus == '0) ? 32'd1 : seq_plus;
          count_d              = count_q + 1'b1;
        end
      end
      CMD_ACK: begin
        if (count_q == '0 || rd_entry.sequence_nr != ack_seq_q) begin
          ev      = EV_UNEXP_ACK;
          res_seq = ack_seq_q;
        end else begin
          res_seq    = rd_entry.sequence_nr;
          res_handle = rd_entry.handle;
          res_length = rd_entry.length;
          res_att    = rd_entry.attempts;
          if (ack_ok_q) begin
            ev      = EV_DELIVERED;
            head_d  = head_inc;
            count_d = count_q - 1'b1;
          end else begin
            ev = EV_NACK;
          end
        end
      end
      CMD_TICK: begin
        if (count_q != '0) begin
          if (rd_entry.attempts != '0 && elapsed < {16'd0, retry_interval_q}) begin
            ev = EV_IDLE;  // interval still running
          end else begin
            res_seq    = rd_entry.sequence_nr;
            res_handle = rd_entry.handle;
            res_length = rd_entry.length;
            if (rd_entry.attempts >= max_attempts_q) begin
              ev      = EV_FAILED;
              res_att = rd_entry.attempts;
              head_d  = head_inc;
              count_d = count_q - 1'b1;
            end else begin
              ev                 = EV_TRANSMIT;
              res_att            = rd_entry.attempts + 1'b1;
              ram_we             = 1'b1;
              wr_entry.attempts  = rd_entry.attempts + 1'b1;
              wr_entry.last_sent = now_q;
            end
          end
        end
      end
      default: ev = EV_IDLE;
    endcase
    // nothing commits until the result register can take the result
    if (!fire) begin
      ram_we     = 1'b0;
      head_d     = head_q;
      count_d    = count_q;
      next_seq_d = next_seq_q;
    end
  end

  // --- state and configuration ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      head_q           <= '0;
      count_q          <= '0;
      retry_interval_q <= RetryIntervalRst;
      max_attempts_q   <= MaxAttemptsRst;
      next_seq_q       <= StartSequenceRst;
      out_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (cfg_we_i && cfg_index_i == CFG_START_SEQUENCE) begin
        next_seq_q <= (cfg_data_i == '0) ? 32'd1 : cfg_data_i;
      end else begin
        next_seq_q <= next_seq_d;
      end
      if (cfg_we_i && cfg_index_i == CFG_RETRY_INTERVAL) begin
        retry_interval_q <= cfg_data_i[15:0];
      end
      if (cfg_we_i && cfg_index_i == CFG_MAX_ATTEMPTS) begin
        max_attempts_q <= cfg_data_i[3:0];
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --- payload registers ---
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_e'(command_i);
      handle_q  <= message_handle_i;
      length_q  <= payload_length_i;
      ack_seq_q <= ack_sequence_i;
      ack_ok_q  <= ack_ok_i;
      now_q     <= now_ms_i;
    end
    if (fire) begin
      event_q      <= ev;
      seq_res_q    <= res_seq;
      handle_res_q <= res_handle;
      length_res_q <= res_length;
      att_res_q    <= res_att;
      depth_res_q  <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = event_q;
  assign sequence_res_o  = seq_res_q;
  assign out_handle_o    = handle_res_q;
  assign out_length_o    = length_res_q;
  assign attempt_count_o = att_res_q;
  assign queue_depth_o   = depth_res_q;

endmodule

### rtl/crq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module crq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/crq_checker.sv
// Port-level checker for command_retry_queue_core, attached by bind.
// Depends on crq_pkg and command_retry_queue_core_assert.svh.
`include "command_retry_queue_core_assert.svh"

module crq_checker #(
  parameter int unsigned QUEUE_DEPTH = crq_pkg::QueueDepthDef
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [3:0]                       event_res_o,
  input logic [31:0]                      sequence_res_o,
  input logic [3:0]                       attempt_count_o,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_depth_o
);

  import crq_pkg::*;

  localparam int unsigned     CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthMax = CntW'(QUEUE_DEPTH);

  logic enq_res;
  logic enq_fields_ok;

  assign enq_res       = out_valid_o && event_res_o == EV_ENQUEUED;
  assign enq_fields_ok = sequence_res_o != '0 && attempt_count_o == '0 && queue_depth_o != '0;

  // a stalled result transaction stays offered
  `CRQ_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)

  // one transaction at a time: busy in the cycle after an accept
  `CRQ_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)

  // occupancy never exceeds the queue depth
  `CRQ_ASSERT(a_depth_bound, clk_i, rst_ni, out_valid_o |-> queue_depth_o <= DepthMax)

  // an enqueued command carries a non-zero sequence number, no attempts and a non-zero depth
  `CRQ_ASSERT(a_enq_fields, clk_i, rst_ni, enq_res |-> enq_fields_ok)

endmodule

bind command_retry_queue_core crq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_crq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .event_res_o    (event_res_o),
  .sequence_res_o (sequence_res_o),
  .attempt_count_o(attempt_count_o),
  .queue_depth_o  (queue_depth_o)
);

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for command_retry_queue_core: drives enqueue, ack and tick
// transactions and checks every result against a behavioural retransmit queue.
// Depends on crq_pkg and the core RTL only.
module tb;
  import crq_pkg::*;

  localparam int unsigned Depth  = QueueDepthDef;
  localparam int unsigned DepthW = $clog2(Depth + 1);
  // command encoding the core must treat as a no-op
  localparam logic [1:0]  CmdReserved = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  handle;
    logic [9:0]  length;
    logic [31:0] ack_seq;
    logic        ack_ok;
    logic [31:0] now;
  } cmd_item_t;

  typedef struct packed {
    event_e            ev;
    logic [31:0]       seq_nr;
    logic [7:0]        handle;
    logic [9:0]        length;
    logic [3:0]        attempts;
    logic [DepthW-1:0] depth;
  } outcome_t;

  // Behavioural copy of the retransmit queue plus the list of results still owed.
  class command_queue_tracker;
    logic [15:0] retry_interval;
    logic [3:0]  attempt_limit;
    logic [31:0] next_seq;
    logic [31:0] slot_seq[Depth];
    logic [7:0]  slot_handle[Depth];
    logic [9:0]  slot_length[Depth];
    logic [31:0] slot_sent_at[Depth];
    logic [3:0]  slot_attempts[Depth];
    int unsigned head_slot;
    int unsigned occupancy;
    outcome_t    outcomes_due[$];
    int unsigned mismatches;

    function new();
      retry_interval = RetryIntervalRst;
      attempt_limit  = MaxAttemptsRst;
      next_seq       = StartSequenceRst;
      head_slot      = 0;
      occupancy      = 0;
      mismatches     = 0;
      foreach (slot_attempts[i]) slot_attempts[i] = '0;
    endfunction

    function void write_reg(input cfg_idx_e idx, input logic [31:0] data);
      case (idx)
        CFG_RETRY_INTERVAL: retry_interval = data[15:0];
        CFG_MAX_ATTEMPTS:   attempt_limit = data[3:0];
        CFG_START_SEQUENCE: next_seq = (data == 32'h0) ? 32'h1 : data;
        default: ;
      endcase
    endfunction

    function void pop_head();
      slot_attempts[head_slot] = '0;
      head_slot = (head_slot + 1) % Depth;
      occupancy--;
    endfunction

    function outcome_t next_outcome(input cmd_item_t it);
      outcome_t    o;
      int unsigned tail;
      int unsigned h;
      logic [31:0] elapsed;
      logic [3:0]  att;
      o    = '0;
      o.ev = EV_IDLE;
      h    = head_slot;
      case (it.cmd)
        CMD_ENQUEUE: begin
          o.handle = it.handle;
          o.length = it.length;
          // length is checked before free space
          if (it.length > MaxPayload) begin
            o.ev = EV_BAD_LENGTH;
          end else if (occupancy >= Depth) begin
            o.ev = EV_FULL;
          end else begin
            tail = (h + occupancy) % Depth;
            slot_seq[tail]      = next_seq;
            slot_handle[tail]   = it.handle;
            slot_length[tail]   = it.length;
            slot_sent_at[tail]  = '0;
            slot_attempts[tail] = '0;
            o.ev     = EV_ENQUEUED;
            o.seq_nr = next_seq;
            next_seq = next_seq + 32'h1;
            if (next_seq == 32'h0) next_seq = 32'h1;
            occupancy++;
          end
        end
        CMD_ACK: begin
          if (occupancy == 0 || slot_seq[h] != it.ack_seq) begin
            o.ev     = EV_UNEXP_ACK;
            o.seq_nr = it.ack_seq;
          end else begin
            o.seq_nr   = slot_seq[h];
            o.handle   = slot_handle[h];
            o.length   = slot_length[h];
            o.attempts = slot_attempts[h];
            if (it.ack_ok) begin
              o.ev = EV_DELIVERED;
              pop_head();
            end else begin
              o.ev = EV_NACK;
            end
          end
        end
        CMD_TICK: begin
          if (occupancy != 0) begin
            att     = slot_attempts[h];
            elapsed = it.now - slot_sent_at[h];
            if (att == 4'h0 || elapsed >= {16'h0, retry_interval}) begin
              o.seq_nr = slot_seq[h];
              o.handle = slot_handle[h];
              o.length = slot_length[h];
              if (att >= attempt_limit) begin
                o.ev       = EV_FAILED;
                o.attempts = att;
                pop_head();
              end else begin
                o.ev       = EV_TRANSMIT;
                o.attempts = att + 4'h1;
                slot_attempts[h] = att + 4'h1;
                slot_sent_at[h]  = it.now;
              end
            end
          end
        end
        default: ;
      endcase
      o.depth = DepthW'(occupancy);
      return o;
    endfunction

    function void note_transaction(input cmd_item_t it);
      outcomes_due.push_back(next_outcome(it));
    endfunction

    function void check_result(input outcome_t got);
      outcome_t want;
      if (outcomes_due.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: result with nothing outstanding: ev=%0d seq=%h",
                   got.ev, got.seq_nr);
        mismatches++;
        return;
      end
      want = outcomes_due.pop_front();
      if (got.ev !== want.ev || got.seq_nr !== want.seq_nr || got.handle !== want.handle ||
          got.length !== want.length || got.attempts !== want.attempts ||
          got.depth !== want.depth) begin
        if (mismatches < 10) begin
          $display("ERROR: expected ev=%0d seq=%h handle=%h len=%0d att=%0d depth=%0d",
                   want.ev, want.seq_nr, want.handle, want.length, want.attempts,
                   want.depth);
          $display("       actual   ev=%0d seq=%h handle=%h len=%0d att=%0d depth=%0d",
                   got.ev, got.seq_nr, got.handle, got.length, got.attempts, got.depth);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni           = 1'b0;
  logic              cfg_we_i         = 1'b0;
  logic [1:0]        cfg_index_i      = '0;
  logic [31:0]       cfg_data_i       = '0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic [1:0]        command_i        = '0;
  logic [7:0]        message_handle_i = '0;
  logic [9:0]        payload_length_i = '0;
  logic [31:0]       ack_sequence_i   = '0;
  logic              ack_ok_i         = 1'b0;
  logic [31:0]       now_ms_i         = '0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [3:0]        event_res_o;
  logic [31:0]       sequence_res_o;
  logic [7:0]        out_handle_o;
  logic [9:0]        out_length_o;
  logic [3:0]        attempt_count_o;
  logic [DepthW-1:0] queue_depth_o;

  command_queue_tracker retry_tracker = new();

  logic [31:0] clock_ms   = '0;  // running millisecond time for ticks
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_run  = 0;

  command_retry_queue_core #(
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .message_handle_i,
    .payload_length_i,
    .ack_sequence_i,
    .ack_ok_i,
    .now_ms_i,
    .out_valid_o,
    .out_stall_i,
    .event_res_o,
    .sequence_res_o,
    .out_handle_o,
    .out_length_o,
    .attempt_count_o,
    .queue_depth_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver back-pressure: stretches of no stall, light random stall and heavy stall.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_run  <= $urandom_range(5, 60);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 1) == 1);
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin : result_monitor
    outcome_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.ev       = event_e'(event_res_o);
      got.seq_nr   = sequence_res_o;
      got.handle   = out_handle_o;
      got.length   = out_length_o;
      got.attempts = attempt_count_o;
      got.depth    = queue_depth_o;
      retry_tracker.check_result(got);
    end
  end

  function automatic cmd_item_t mk(input logic [1:0] cmd, input logic [7:0] handle,
                                   input logic [9:0] length, input logic [31:0] ack_seq,
                                   input logic ack_ok, input logic [31:0] now);
    cmd_item_t it;
    it.cmd     = cmd;
    it.handle  = handle;
    it.length  = length;
    it.ack_seq = ack_seq;
    it.ack_ok  = ack_ok;
    it.now     = now;
    return it;
  endfunction

  // Mostly well-formed traffic: acks usually carry the head's sequence, lengths usually
  // legal; unused fields are random so every input bit toggles.
  function automatic cmd_item_t random_item();
    cmd_item_t   it;
    int unsigned pick;
    int unsigned step_max;
    pick       = $urandom_range(0, 99);
    it.handle  = 8'($urandom);
    it.length  = 10'($urandom);
    it.ack_seq = $urandom;
    it.ack_ok  = 1'($urandom);
    it.now     = $urandom;
    if (pick < 25) begin
      it.cmd = CMD_ENQUEUE;
      if ($urandom_range(0, 99) < 85) it.length = 10'($urandom_range(0, MaxPayload));
    end else if (pick < 65) begin
      it.cmd   = CMD_TICK;
      step_max = retry_tracker.retry_interval / 3 + 2;
      if ($urandom_range(0, 49) == 0) clock_ms = clock_ms + $urandom;
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      it.now = clock_ms;
    end else if (pick < 95) begin
      it.cmd = CMD_ACK;
      if (retry_tracker.occupancy != 0 && $urandom_range(0, 4) != 0)
        it.ack_seq = retry_tracker.slot_seq[retry_tracker.head_slot];
      it.ack_ok = ($urandom_range(0, 3) != 0);
    end else begin
      it.cmd = CmdReserved;
    end
    return it;
  endfunction

  // Sends one transaction, opening a new burst after a random gap when the last one ran out.
  task automatic drive_item(input cmd_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    command_i        <= it.cmd;
    message_handle_i <= it.handle;
    payload_length_i <= it.length;
    ack_sequence_i   <= it.ack_seq;
    ack_ok_i         <= it.ack_ok;
    now_ms_i         <= it.now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    retry_tracker.note_transaction(it);
  endtask

  // Waits for every owed result, then for the core to go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (retry_tracker.outcomes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [15:0] interval, input logic [3:0] limit,
                           input logic [31:0] first_seq, input int unsigned n_items);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_RETRY_INTERVAL;
    cfg_data_i  <= {16'h0, interval};
    @(posedge clk_i);
    retry_tracker.write_reg(CFG_RETRY_INTERVAL, {16'h0, interval});
    cfg_index_i <= CFG_MAX_ATTEMPTS;
    cfg_data_i  <= {28'h0, limit};
    @(posedge clk_i);
    retry_tracker.write_reg(CFG_MAX_ATTEMPTS, {28'h0, limit});
    cfg_index_i <= CFG_START_SEQUENCE;
    cfg_data_i  <= first_seq;
    @(posedge clk_i);
    retry_tracker.write_reg(CFG_START_SEQUENCE, first_seq);
    cfg_we_i <= 1'b0;
    clock_ms = $urandom;
    repeat (n_items) drive_item(random_item());
  endtask

  initial begin
    cmd_item_t   directed[$];
    logic [31:0] base;
    base = 32'hFFFF_FE00;  // retries cross the 2^32 wrap of the millisecond time
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk at reset settings (interval 1000, three attempts).
    directed.push_back(mk(CMD_TICK,    8'h00, 10'd0,    32'h0,         1'b0, base));
    directed.push_back(mk(CMD_ACK,     8'h00, 10'd0,    32'h0,         1'b1, base));
    directed.push_back(mk(CmdReserved, 8'hFF, 10'd1023, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    directed.push_back(mk(CMD_ENQUEUE, 8'h00, 10'd0,    32'h0,         1'b0, base));
    directed.push_back(mk(CMD_ENQUEUE, 8'hFF, 10'd512,  32'h0,         1'b0, base));
    directed.push_back(mk(CMD_ENQUEUE, 8'h5A, 10'd513,  32'h0,         1'b0, base));
    directed.push_back(mk(CMD_ENQUEUE, 8'hA5, 10'd1023, 32'h0,         1'b0, base));
    directed.push_back(mk(CMD_ENQUEUE, 8'h11, 10'd100,  32'h0,         1'b0, base));
    directed.push_back(mk(CMD_ENQUEUE, 8'h22, 10'd200,  32'h0,         1'b0, base));
    // queue now full; an oversize length still reports bad length first
    directed.push_back(mk(CMD_ENQUEUE, 8'h33, 10'd1,    32'h0,         1'b0, base));
    directed.push_back(mk(CMD_ENQUEUE, 8'h44, 10'd600,  32'h0,         1'b0, base));
    // ack taken before the head was ever sent
    directed.push_back(mk(CMD_ACK,     8'h00, 10'd0,    32'd1,         1'b1, base));
    directed.push_back(mk(CMD_TICK,    8'h00, 10'd0,    32'h0,         1'b0, base));
    directed.push_back(mk(CMD_TICK,    8'h00, 10'd0,    32'h0,         1'b0, base + 999));
    directed.push_back(mk(CMD_ACK,     8'h00, 10'd0,    32'd2,         1'b0, base));
    directed.push_back(mk(CMD_ACK,     8'h00, 10'd0,    32'hFFFF_FFFF, 1'b1, base));
    directed.push_back(mk(CMD_TICK,    8'h00, 10'd0,    32'h0,         1'b0, base + 1000));
    directed.push_back(mk(CMD_TICK,    8'h00, 10'd0,    32'h0,         1'b0, base + 2000));
    // attempts spent and interval run out: head dropped as failed
    directed.push_back(mk(CMD_TICK,    8'h00, 10'd0,    32'h0,         1'b0, base + 3000));
    directed.push_back(mk(CMD_TICK,    8'h00, 10'd0,    32'h0,         1'b0, base + 3000));
    directed.push_back(mk(CMD_ACK,     8'h00, 10'd0,    32'd3,         1'b1, base));
    directed.push_back(mk(CMD_ACK,     8'h00, 10'd0,    32'd4,         1'b0, base));
    foreach (directed[i]) drive_item(directed[i]);

    // Extremes: zero interval with start sequence zero, widest interval with the
    // sequence about to wrap, and an attempt limit of zero.
    run_phase(16'd0,      4'd1,  32'd0,         150);
    run_phase(16'hFFFF,   4'd15, 32'hFFFF_FFFD, 150);
    run_phase(16'd5,      4'd0,  $urandom,      120);
    for (int p = 0; p < 6; p++) begin
      run_phase(16'($urandom_range(0, 200)), 4'($urandom_range(1, 15)), $urandom, 150);
    end

    settle();
    if (retry_tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: ends the run with an error if it has not finished.
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### command_retry_queue_core.f
+incdir+rtl
rtl/crq_pkg.sv
rtl/crq_ram.sv
rtl/command_retry_queue_core.sv
rtl/crq_checker.sv
dv/tb.sv
